// ----- hw/rtl/bbw_pkg.sv -----
// Shared constants, types and codes for the bounded bitstream writer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bbw_pkg;

   // Byte store geometry
   localparam int unsigned STORE_BYTES = 1024;
   localparam int unsigned IDX_W       = $clog2(STORE_BYTES);

   // Field widths
   localparam int unsigned REG_W   = 13;
   localparam int unsigned POS_W   = 14;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned CNT_W   = 6;
   localparam int unsigned RADDR_W = 10;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MAX_BITS = 32;
   localparam int unsigned CURSOR_MAX = 8192;

   // Packed transaction widths
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 24;

   // Byte position of a bit cursor, and its reduction modulo the store size
   localparam int unsigned X_W         = POS_W - 3;
   localparam int unsigned RECIP_SHIFT = 2 * X_W;
   localparam int unsigned RECIP_W     = 19;
   localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / STORE_BYTES;
   localparam int unsigned PROD_W      = X_W + RECIP_W;
   localparam int unsigned Q_W         = PROD_W - RECIP_SHIFT;

   // A write spans at most 7 + 32 bits, i.e. five bytes
   localparam int unsigned SPAN_W    = 40;
   localparam int unsigned MAX_BYTES = 5;
   localparam int unsigned BCNT_W    = 3;

   // Register indexes
   localparam logic [1:0] CSR_WINDOW_FIRST = 2'd0;
   localparam logic [1:0] CSR_WINDOW_LAST  = 2'd1;
   localparam logic [1:0] CSR_START_BIT    = 2'd2;

   // Action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUOT,
      ST_REM,
      ST_RD_WAIT,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } merge_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bounded_bitstream_writer.sv -----
// Bounded bitstream writer: packs 0 to 32 value bits LSB first into a byte
// store at a bit cursor, within a configured end-bit window. After reset the
// block clears every byte of the store with req_tready low; configuration
// writes are taken during that pass. One transaction is worked at a time: a
// read passes through quotient, remainder, read-wait and finishing steps; a
// write touches 0 to 5 bytes, each a read-modify-write through the one byte
// store port, and a rejected or zero-length write touches none. The first
// byte index is reduced modulo the store size by a reciprocal multiply, as a
// quotient step then a remainder step. A finished result waits in an output
// register, so the next transaction can be accepted meanwhile.
// Depends on bbw_pkg, bbw_byte_ram and bbw_merge_unit.
`default_nettype none

module bounded_bitstream_writer
   import bbw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: tdata = value[31:0], bit_total[37:32], read_address[47:38]
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,   // action[0]
   // response: tdata = accepted[0], cursor_after[14:1], read_byte[22:15]
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [REG_W-1:0]      csr_wr_data
);

   state_type state_ff, state_in;

   logic              action_ff, action_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              ok_ff, ok_in;
   logic [BCNT_W-1:0] bytes_ff, bytes_in;
   logic [POS_W-1:0]  cursor_ff, cursor_in;
   logic [REG_W-1:0]  win_first_ff, win_first_in;
   logic [REG_W-1:0]  win_last_ff, win_last_in;
   logic [BYTE_W-1:0] rbyte_ff, rbyte_in;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic              rsp_accepted_ff, rsp_accepted_in;
   logic [POS_W-1:0]  rsp_cursor_ff, rsp_cursor_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   logic [CNT_W-1:0]  req_count;
   logic [PROD_W-1:0] prod;
   logic [X_W-1:0]    rem;
   logic [X_W-1:0]    rem_red;
   logic [IDX_W-1:0]  idx_red;
   logic [IDX_W-1:0]  idx_next;
   logic [POS_W:0]    end_sum;
   logic              in_window;
   logic [CNT_W-1:0]  span_top;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;
   merge_ctrl_type    merge_ctrl;
   logic [BYTE_W-1:0] merged_byte;

   bbw_byte_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bbw_merge_unit u_merge (
      .clock    (clock),
      .ctrl     (merge_ctrl),
      .value    (value_ff),
      .count    (count_ff),
      .offset   (cursor_ff[2:0]),
      .old_byte (ram_rd_data),
      .new_byte (merged_byte)
   );

   // Saturate the bit count at 32
   assign req_count = (req_tdata[37:32] > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS)
                                                            : req_tdata[37:32];

   // Byte index reduction: quotient estimate, then remainder with one correction
   assign prod    = PROD_W'(x_ff) * PROD_W'(RECIP);
   assign rem     = x_ff - X_W'(32'(q_ff) * STORE_BYTES);
   assign rem_red = (32'(rem) >= STORE_BYTES) ? (rem - X_W'(STORE_BYTES)) : rem;
   assign idx_red = IDX_W'(rem_red);

   // Next byte index, wrapping at the end of the store
   assign idx_next = (idx_ff == IDX_W'(STORE_BYTES - 1)) ? '0 : idx_ff + IDX_W'(1);

   // Window check on the last written bit (cursor + count - 1)
   assign end_sum   = (POS_W+1)'(cursor_ff) + (POS_W+1)'(count_ff);
   assign in_window = (end_sum >= (POS_W+1)'(win_first_ff) + (POS_W+1)'(1)) &&
                      (end_sum <= (POS_W+1)'(win_last_ff) + (POS_W+1)'(1));

   // Highest bit offset of the span inside the aligned window
   assign span_top = CNT_W'(cursor_ff[2:0]) + count_ff - CNT_W'(1);

   // Sequencer: next state, datapath updates and store port control
   always_comb begin
      state_in        = state_ff;
      action_in       = action_ff;
      value_in        = value_ff;
      count_in        = count_ff;
      x_in            = x_ff;
      q_in            = q_ff;
      idx_in          = idx_ff;
      ok_in           = ok_ff;
      bytes_in        = bytes_ff;
      cursor_in       = cursor_ff;
      win_first_in    = win_first_ff;
      win_last_in     = win_last_ff;
      rbyte_in        = rbyte_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_byte_in     = rsp_byte_ff;
      req_tready      = 1'b0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = idx_ff;
      ram_wr_data     = merged_byte;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = idx_ff;
      merge_ctrl      = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
            idx_in      = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(STORE_BYTES - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               action_in = req_tuser;
               value_in  = req_tdata[31:0];
               count_in  = req_count;
               x_in      = (req_tuser == ACT_READ) ? X_W'(req_tdata[47:38])
                                                   : cursor_ff[POS_W-1:3];
               state_in  = ST_QUOT;
            end
         end
         ST_QUOT: begin
            q_in     = prod[PROD_W-1:RECIP_SHIFT];
            ok_in    = (action_ff == ACT_WRITE) && in_window;
            state_in = ST_REM;
         end
         ST_REM: begin
            idx_in = idx_red;
            if (action_ff == ACT_READ) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_red;
               state_in    = ST_RD_WAIT;
            end else if (ok_ff && (count_ff != '0)) begin
               merge_ctrl.load = 1'b1;
               bytes_in = BCNT_W'(span_top >> 3) + BCNT_W'(1);
               state_in = ST_RMW_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD_WAIT: begin
            rbyte_in = ram_rd_data;
            state_in = ST_DONE;
         end
         ST_RMW_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            ram_wr_en       = 1'b1;
            merge_ctrl.step = 1'b1;
            bytes_in        = bytes_ff - BCNT_W'(1);
            idx_in          = idx_next;
            state_in        = (bytes_ff == BCNT_W'(1)) ? ST_DONE : ST_RMW_RD;
         end
         ST_DONE: begin
            // Hand the result over once the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in   = 1'b1;
               rsp_accepted_in = ok_ff;
               rsp_cursor_in   = ok_ff ? (cursor_ff + POS_W'(count_ff)) : cursor_ff;
               rsp_byte_in     = (action_ff == ACT_READ) ? rbyte_ff : '0;
               cursor_in       = ok_ff ? (cursor_ff + POS_W'(count_ff)) : cursor_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_FIRST: win_first_in = csr_wr_data;
            CSR_WINDOW_LAST:  win_last_in  = csr_wr_data;
            CSR_START_BIT:    cursor_in    = POS_W'(csr_wr_data);
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         cursor_ff     <= '0;
         win_first_ff  <= '0;
         win_last_ff   <= REG_W'(CURSOR_MAX - 1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cursor_ff     <= cursor_in;
         win_first_ff  <= win_first_in;
         win_last_ff   <= win_last_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff       <= action_in;
      value_ff        <= value_in;
      count_ff        <= count_in;
      x_ff            <= x_in;
      q_ff            <= q_in;
      ok_ff           <= ok_in;
      bytes_ff        <= bytes_in;
      rbyte_ff        <= rbyte_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_byte_ff     <= rsp_byte_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_byte_ff, rsp_cursor_ff, rsp_accepted_ff};

   // An accepted transaction always moves on to the quotient step
   a_accept_to_quot: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_QUOT))
      else $error("accepted transaction did not enter quotient step");

   // The cursor never passes the end of the bit space
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= POS_W'(CURSOR_MAX))
      else $error("bit cursor out of range");

   // Byte countdown stays within a five-byte span during read-modify-write
   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RMW_RD || state_ff == ST_RMW_WR) |->
      (bytes_ff >= BCNT_W'(1) && bytes_ff <= BCNT_W'(MAX_BYTES)))
      else $error("byte count out of range");

   // The store is written only by the clearing pass or a merge step
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_RMW_WR))
      else $error("store written outside clear or merge");

   // A new result appears only after the finishing step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside finishing step");

endmodule

`default_nettype wire

// ----- hw/rtl/bbw_byte_ram.sv -----
// Single-port-write, single-port-read byte store with registered read data.
// Depends on bbw_pkg for the store size.
`default_nettype none

module bbw_byte_ram
   import bbw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output      logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_ff [STORE_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bbw_merge_unit.sv -----
// Shift-and-merge unit: aligns the value at the bit offset once, then
// merges one byte per step into the old store byte under a bit mask.
// Depends on bbw_pkg.
`default_nettype none

module bbw_merge_unit
   import bbw_pkg::*;
(
   input  wire logic              clock,
   input  wire merge_ctrl_type    ctrl,
   input  wire logic [VAL_W-1:0]  value,
   input  wire logic [CNT_W-1:0]  count,
   input  wire logic [2:0]        offset,
   input  wire logic [BYTE_W-1:0] old_byte,
   output      logic [BYTE_W-1:0] new_byte
);

   logic [SPAN_W-1:0] data_ff, data_in;
   logic [SPAN_W-1:0] mask_ff, mask_in;
   logic [VAL_W-1:0]  low_mask;

   // Keep only the low count bits (count is at most 32)
   assign low_mask = VAL_W'((33'(1) << count) - 33'(1));

   // Load aligned span, or advance one byte
   always_comb begin
      data_in = data_ff;
      mask_in = mask_ff;
      if (ctrl.load) begin
         data_in = SPAN_W'(value & low_mask) << offset;
         mask_in = SPAN_W'(low_mask) << offset;
      end else if (ctrl.step) begin
         data_in = data_ff >> BYTE_W;
         mask_in = mask_ff >> BYTE_W;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      mask_ff <= mask_in;
   end

   // Merge the current byte under its mask
   assign new_byte = (old_byte & ~mask_ff[BYTE_W-1:0]) |
                     (data_ff[BYTE_W-1:0] & mask_ff[BYTE_W-1:0]);

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the bounded bitstream writer: directed edge cases, then
// randomized phases of writes and reads under changing window settings.
// Depends on bbw_pkg and the bounded_bitstream_writer RTL.

module testbench
   import bbw_pkg::*;
;

   localparam int TOTAL_ITEMS    = 1100;
   localparam int QUIET_FROM     = 950;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 20;

   // Expected response of one transaction
   typedef struct {
      logic              accepted;
      logic [POS_W-1:0]  cursor_after;
      logic [BYTE_W-1:0] read_byte;
   } packer_result_type;

   // Tracks the store, the cursor and the window, and holds predicted responses
   class bitstream_scoreboard;
      logic [BYTE_W-1:0] store [STORE_BYTES];
      logic [POS_W-1:0]  cursor;
      logic [REG_W-1:0]  win_lo;
      logic [REG_W-1:0]  win_hi;
      packer_result_type predicted_results [$];
      int                errors;

      function new();
         foreach (store[i]) store[i] = '0;
         win_lo = '0;
         win_hi = REG_W'(CURSOR_MAX - 1);
         cursor = '0;
         errors = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [REG_W-1:0] val);
         case (idx)
            CSR_WINDOW_FIRST: win_lo = val;
            CSR_WINDOW_LAST:  win_hi = val;
            CSR_START_BIT:    cursor = POS_W'(val);
            default: ;
         endcase
      endfunction

      function int pending();
         return predicted_results.size();
      endfunction

      // Predict the response of one accepted transaction
      function void note_request(logic act, logic [VAL_W-1:0] value,
                                 logic [CNT_W-1:0] count, logic [RADDR_W-1:0] raddr);
         packer_result_type r;
         int unsigned       n;
         int unsigned       pos;
         int                end_bit;
         r.accepted  = 1'b0;
         r.read_byte = '0;
         if (act == ACT_READ) begin
            r.read_byte = store[raddr % STORE_BYTES];
         end else begin
            n = (count > MAX_BITS) ? MAX_BITS : count;
            end_bit = int'(cursor) + int'(n) - 1;
            if (end_bit >= int'(win_lo) && end_bit <= int'(win_hi)) begin
               for (int i = 0; i < n; i++) begin
                  pos = cursor + i;
                  store[(pos >> 3) % STORE_BYTES][pos & 7] = value[i];
               end
               cursor = cursor + POS_W'(n);
               r.accepted = 1'b1;
            end
         end
         r.cursor_after = cursor;
         predicted_results.push_back(r);
      endfunction

      // Compare one response with the oldest prediction
      function void check_response(logic [RSP_DATA_W-1:0] data);
         packer_result_type want;
         if (predicted_results.size() == 0) begin
            $error("response with nothing expected: tdata %h", data);
            errors++;
            return;
         end
         want = predicted_results.pop_front();
         if (data[0] !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, data[0]);
            errors++;
         end
         if (data[14:1] !== want.cursor_after) begin
            $error("cursor_after: expected %0d, got %0d", want.cursor_after, data[14:1]);
            errors++;
         end
         if (data[22:15] !== want.read_byte) begin
            $error("read_byte: expected %h, got %h", want.read_byte, data[22:15]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = ACT_WRITE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [1:0]            csr_index = CSR_WINDOW_FIRST;
   logic [REG_W-1:0]      csr_wr_data = '0;

   bitstream_scoreboard board;
   int                  items_sent = 0;
   bit                  idle_on = 1'b1;
   int                  stall_left = 0;
   int                  quiet_cycles = 0;

   bounded_bitstream_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit idling();
      return idle_on && items_sent < QUIET_FROM;
   endfunction

   // Stall the response side in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling() && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check responses and watch for a hung block
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offer one transaction, holding it until accepted
   task automatic send_item(input logic act, input logic [VAL_W-1:0] val,
                            input logic [CNT_W-1:0] cnt, input logic [RADDR_W-1:0] addr);
      if (idling() && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {addr, cnt, val};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(act, val, cnt, addr);
      items_sent++;
   endtask

   // Hold off the sender until every predicted response has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_register(input logic [1:0] idx, input logic [REG_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      board.set_register(idx, val);
   endtask

   // Drain, then program the selected registers back to back
   task automatic apply_settings(input bit set_first, input bit set_last, input bit set_start,
                                 input logic [REG_W-1:0] first, input logic [REG_W-1:0] last,
                                 input logic [REG_W-1:0] start);
      drain_results();
      if (set_first) put_register(CSR_WINDOW_FIRST, first);
      if (set_last)  put_register(CSR_WINDOW_LAST, last);
      if (set_start) put_register(CSR_START_BIT, start);
      csr_wr_en <= 1'b0;
   endtask

   // Random mix of reads and mostly in-window writes
   task automatic run_random(input int count);
      int                 headroom;
      logic [VAL_W-1:0]   val;
      logic [CNT_W-1:0]   cnt;
      logic [RADDR_W-1:0] addr;
      for (int k = 0; k < count; k++) begin
         val  = $urandom();
         addr = $urandom_range(0, STORE_BYTES - 1);
         if ($urandom_range(0, 9) < 4) begin
            // read near the cursor most of the time
            if ($urandom_range(0, 2) != 0)
               addr = RADDR_W'(int'(board.cursor >> 3) - int'($urandom_range(0, 6)));
            send_item(ACT_READ, val, CNT_W'($urandom_range(0, 63)), addr);
         end else begin
            headroom = int'(board.win_hi) - int'(board.cursor) + 1;
            if (headroom > 0 && $urandom_range(0, 19) != 0)
               cnt = CNT_W'($urandom_range(0, headroom < 32 ? headroom : 32));
            else
               cnt = CNT_W'($urandom_range(0, 63));
            if ($urandom_range(0, 15) == 0)
               val = $urandom_range(0, 1) ? '1 : '0;
            send_item(ACT_WRITE, val, cnt, addr);
         end
      end
   endtask

   initial begin
      logic [REG_W-1:0] first;
      logic [REG_W-1:0] last;
      logic [REG_W-1:0] start;
      bit               set_start;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Default window: zero-length at cursor 0, saturation, partial bytes
      send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd0, 10'd0);
      send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd32, 10'd0);
      send_item(ACT_WRITE, 32'h0000_0000, 6'd1, 10'd0);
      send_item(ACT_WRITE, 32'hA5A5_5A5A, 6'd63, 10'd0);
      send_item(ACT_WRITE, 32'h1234_5678, 6'd33, 10'd0);
      send_item(ACT_WRITE, 32'h0000_0015, 6'd5, 10'd0);
      send_item(ACT_WRITE, 32'hDEAD_BEEF, 6'd0, 10'd0);
      send_item(ACT_READ, 32'h0, 6'd0, 10'd0);
      send_item(ACT_READ, 32'h0, 6'd0, 10'd4);
      send_item(ACT_READ, 32'h0, 6'd0, 10'd8);
      send_item(ACT_READ, 32'h0, 6'd0, 10'd12);
      send_item(ACT_READ, 32'hFFFF_FFFF, 6'd63, 10'd1023);

      // One-bit window at the top of the range
      apply_settings(1'b1, 1'b1, 1'b1, 13'd8191, 13'd8191, 13'd8180);
      send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd11, 10'd0);
      send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd13, 10'd0);
      send_item(ACT_WRITE, 32'h0000_0ABC, 6'd12, 10'd0);
      send_item(ACT_WRITE, 32'h0000_0000, 6'd0, 10'd0);
      send_item(ACT_WRITE, 32'h0000_0001, 6'd1, 10'd0);
      send_item(ACT_READ, 32'h0, 6'd0, 10'd1023);
      send_item(ACT_READ, 32'h0, 6'd0, 10'd1022);

      // Empty window: everything rejected
      apply_settings(1'b1, 1'b1, 1'b1, 13'd8191, 13'd0, 13'd0);
      send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd0, 10'd0);
      send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd32, 10'd0);
      send_item(ACT_WRITE, 32'hFFFF_FFFF, 6'd1, 10'd0);

      // Window of bit 0 alone
      apply_settings(1'b1, 1'b1, 1'b0, 13'd0, 13'd0, 13'd0);
      send_item(ACT_WRITE, 32'h0000_0000, 6'd1, 10'd0);
      send_item(ACT_WRITE, 32'h0000_0001, 6'd1, 10'd0);
      send_item(ACT_READ, 32'h0, 6'd0, 10'd0);

      // Random phases, each under new settings
      while (items_sent < TOTAL_ITEMS) begin
         set_start = $urandom_range(0, 3) != 0;
         if (set_start)
            start = $urandom_range(0, 7200);
         else
            start = (board.cursor > CURSOR_MAX - 1) ? REG_W'(CURSOR_MAX - 1)
                                                    : REG_W'(board.cursor);
         case ($urandom_range(0, 7))
            0: begin
               first = '0;
               last  = REG_W'(CURSOR_MAX - 1);
            end
            1: begin
               first = $urandom_range(1, CURSOR_MAX - 1);
               last  = $urandom_range(0, first - 1);
            end
            default: begin
               first = $urandom_range(0, 1) ? REG_W'(int'(start) + $urandom_range(0, 40))
                                            : REG_W'($urandom_range(0, start));
               last  = (int'(start) + 1500 > CURSOR_MAX - 1)
                       ? REG_W'(CURSOR_MAX - 1)
                       : REG_W'(int'(start) + $urandom_range(100, 1500));
            end
         endcase
         apply_settings(1'b1, 1'b1, set_start, first, last, start);
         idle_on = $urandom_range(0, 3) != 0;
         run_random($urandom_range(60, 140));
      end

      // Wrap up: drain, settle, report
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/bbw_pkg.sv
hw/rtl/bbw_byte_ram.sv
hw/rtl/bbw_merge_unit.sv
hw/rtl/bounded_bitstream_writer.sv
bench/testbench.sv
